>>> design/fmba_pkg.sv
// Package for the fit-mode block allocator.
// Holds the table entry type, status and register codes and the FSM states.
// No dependencies.
package fmba_pkg;

  localparam int unsigned POOL_BYTES = 65536;  // largest pool, held in POS_W bits
  localparam int unsigned POS_W  = 17;  // block start and pool size
  localparam int unsigned PAY_W  = 17;  // stored payload bytes
  localparam int unsigned END_W  = 19;  // start + header + payload
  localparam int unsigned NEED_W = 33;  // product plus header
  localparam int unsigned UADR_W = 16;

  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_RSVD  = 2'd3
  } fit_t;

  localparam logic CFG_FIT_MODE  = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;
  localparam logic OP_ALLOC      = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_ASCAN, S_INS, S_INSWR, S_FSCAN, S_FSHIFT, S_RESP
  } state_t;

endpackage

>>> design/fmba_table.sv
// Block table memory: one write port, one read port, registered read data.
// Depends on fmba_pkg for the entry type.
module fmba_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                clk,
  input  logic [AW-1:0]       rd_addr,
  output fmba_pkg::entry_t    rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  fmba_pkg::entry_t    wr_data
);
  import fmba_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/fit_mode_block_allocator_core.sv
// Top level of the fit-mode block allocator.
// Depends on fmba_pkg and fmba_table.
//
// Usage:
//   in_*  : requests. in_tuser is op (0 allocate, 1 free); in_tdata carries
//           element_size, element_count and free_address.
//   out_* : one result per request: status, user_address, free_bytes.
//   cfg_* : register writes (0 fit mode, 1 pool size); the user makes them
//           only while idle, as the block does not enforce it.
// One request is handled at a time; in_tready is high only when idle.
// Allocate: accept, a check for a full table or too little free space, a scan
// of count+1 table entries (first fit stops at the first fitting gap), a shift
// of the entries above the chosen slot, a write of the new entry and the
// result. Free: accept, a scan up to the matching entry, the entries above it
// moved down one slot each, and the result. Entries are shifted one at a
// time through the single read and write port of the table memory.
// Reset empties the table (count to zero) and sets free bytes to the pool
// size; no clearing pass is needed. A stalled receiver keeps the result held
// in the output register while the block goes idle; the next request then
// waits in its result cycle until the held transfer is taken.
module fit_mode_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // op
  input  logic [47:0] in_tdata,   // element_size, element_count, free_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status, user_address, free_bytes, zero pad
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);
  import fmba_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned UW = PAY_W + CW + 1;
  localparam logic [24:0] POOL_MAX = 25'(POOL_BYTES);
  localparam logic [POS_W-1:0] PLIM_RST = POS_W'(POOL_BYTES);
  localparam logic [6:0] HDR = 7'(HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, e_r, e_nxt, c_r, c_nxt, pick_r, pick_nxt;
  logic [POS_W-1:0] bfree_r, bfree_nxt, plim_r, plim_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [1:0] fmode_r, fmode_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [15:0] faddr_r, faddr_nxt;
  logic [END_W-1:0] lo_r, lo_nxt, plo_r, plo_nxt;
  logic [POS_W-1:0] best_r, best_nxt;
  logic found_r, found_nxt;
  logic pend_v_r, pend_v_nxt;
  logic [AW-1:0] pend_a_r, pend_a_nxt;
  status_t st_r, st_nxt;
  logic [15:0] ua_r, ua_nxt;
  logic out_v_r, out_v_nxt;
  logic [39:0] out_d_r, out_d_nxt;

  logic [AW-1:0] rd_addr;
  entry_t rd_data, wr_data;
  logic wr_en;
  logic [AW-1:0] wr_addr;

  fmba_table #(.DEPTH(MAX_BLOCKS), .AW(AW)) u_table (
    .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  // gap evaluation for the entry whose data arrives this cycle
  logic [POS_W-1:0] hi, gap;
  logic fits, take;
  logic [END_W-1:0] ent_end;
  logic [END_W:0] bf_sum;
  logic [PAY_W:0] blk_bytes;
  logic [24:0] cfg_plim;

  always_comb begin
    hi = (e_r == cnt_r) ? plim_r : rd_data.start;
    if (hi > plim_r) hi = plim_r;
    gap = ({2'b0, hi} > lo_r) ? POS_W'({2'b0, hi} - lo_r) : '0;
    fits = {16'b0, gap} >= need_r;
    unique case (fit_t'(fmode_r))
      FIT_BEST:  take = fits && (!found_r || gap < best_r);
      FIT_WORST: take = fits && (!found_r || gap >= best_r);
      FIT_FIRST, FIT_RSVD: take = fits;
      default:   take = fits;
    endcase
    blk_bytes = (PAY_W+1)'(rd_data.payload) + (PAY_W+1)'(HDR);
    ent_end = END_W'(rd_data.start) + END_W'(blk_bytes);
    bf_sum = (END_W+1)'(bfree_r) + (END_W+1)'(blk_bytes);
    cfg_plim = ({8'b0, cfg_data} > POOL_MAX) ? POOL_MAX : {8'b0, cfg_data};
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; e_nxt = e_r; c_nxt = c_r;
    pick_nxt = pick_r; bfree_nxt = bfree_r; plim_nxt = plim_r;
    used_nxt = used_r; fmode_nxt = fmode_r; need_nxt = need_r;
    faddr_nxt = faddr_r; lo_nxt = lo_r; plo_nxt = plo_r; best_nxt = best_r;
    found_nxt = found_r; pend_v_nxt = pend_v_r; pend_a_nxt = pend_a_r;
    st_nxt = st_r; ua_nxt = ua_r; out_v_nxt = out_v_r; out_d_nxt = out_d_r;
    rd_addr = '0; wr_en = 1'b0; wr_addr = pend_a_r; wr_data = rd_data;
    in_tready = (state_r == S_IDLE);

    if (out_v_r && out_tready) out_v_nxt = 1'b0;

    if (cfg_wr_en) begin
      if (cfg_index == CFG_FIT_MODE) begin
        fmode_nxt = cfg_data[1:0];
      end else begin
        plim_nxt = POS_W'(cfg_plim);
        bfree_nxt = (used_r >= UW'(cfg_plim)) ? '0 : POS_W'(UW'(cfg_plim) - used_r);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          need_nxt = NEED_W'({16'b0, in_tdata[15:0]} * {16'b0, in_tdata[31:16]})
                     + NEED_W'(HDR);
          faddr_nxt = in_tdata[47:32];
          e_nxt = '0; lo_nxt = '0; found_nxt = 1'b0; best_nxt = '0;
          ua_nxt = '0;
          state_nxt = (in_tuser == OP_ALLOC) ? S_CHECK : S_FSCAN;
        end
      end
      S_CHECK: begin
        if (cnt_r == CNT_MAX) begin
          st_nxt = ST_FULL; state_nxt = S_RESP;
        end else if (need_r > NEED_W'(bfree_r)) begin
          st_nxt = ST_NOFIT; state_nxt = S_RESP;
        end else begin
          state_nxt = S_ASCAN;
        end
      end
      S_ASCAN: begin
        rd_addr = AW'(e_r + 1'b1);
        lo_nxt = ent_end;
        e_nxt = e_r + 1'b1;
        if (take) begin
          best_nxt = gap; pick_nxt = e_r; plo_nxt = lo_r; found_nxt = 1'b1;
        end
        if ((take && (fmode_r != FIT_BEST) && (fmode_r != FIT_WORST))
            || (e_r == cnt_r)) begin
          c_nxt = cnt_r; pend_v_nxt = 1'b0;
          if (found_r || take) begin
            state_nxt = S_INS;
          end else begin
            st_nxt = ST_NOFIT; state_nxt = S_RESP;
          end
        end
      end
      S_INS: begin
        wr_en = pend_v_r;
        if (c_r > pick_r) begin
          rd_addr = AW'(c_r - 1'b1);
          pend_v_nxt = 1'b1; pend_a_nxt = AW'(c_r); c_nxt = c_r - 1'b1;
        end else begin
          pend_v_nxt = 1'b0; state_nxt = S_INSWR;
        end
      end
      S_INSWR: begin
        wr_en = 1'b1;
        wr_addr = AW'(pick_r);
        wr_data.start = POS_W'(plo_r);
        wr_data.payload = PAY_W'(need_r - NEED_W'(HDR));
        cnt_nxt = cnt_r + 1'b1;
        bfree_nxt = bfree_r - POS_W'(need_r);
        used_nxt = used_r + UW'(need_r);
        st_nxt = ST_OK;
        ua_nxt = 16'(plo_r + END_W'(HDR));
        state_nxt = S_RESP;
      end
      S_FSCAN: begin
        rd_addr = AW'(e_r + 1'b1);
        e_nxt = e_r + 1'b1;
        if (e_r == cnt_r) begin
          st_nxt = ST_BADFREE; state_nxt = S_RESP;
        end else if (16'(ent_end - END_W'(rd_data.payload)) == faddr_r) begin
          bfree_nxt = (bf_sum > (END_W+1)'(plim_r)) ? plim_r : POS_W'(bf_sum);
          used_nxt = used_r - UW'(blk_bytes);
          c_nxt = e_r + 1'b1; pend_v_nxt = 1'b0;
          state_nxt = S_FSHIFT;
        end
      end
      S_FSHIFT: begin
        wr_en = pend_v_r;
        if (c_r < cnt_r) begin
          rd_addr = AW'(c_r);
          pend_v_nxt = 1'b1; pend_a_nxt = AW'(c_r - 1'b1); c_nxt = c_r + 1'b1;
        end else begin
          pend_v_nxt = 1'b0; cnt_nxt = cnt_r - 1'b1;
          st_nxt = ST_OK; state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt = 1'b1;
          out_d_nxt = {5'b0, bfree_r, ua_r, st_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; plim_r <= PLIM_RST; bfree_r <= PLIM_RST;
      used_r <= '0; fmode_r <= FIT_FIRST; out_v_r <= 1'b0; pend_v_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; plim_r <= plim_nxt;
      bfree_r <= bfree_nxt; used_r <= used_nxt; fmode_r <= fmode_nxt;
      out_v_r <= out_v_nxt; pend_v_r <= pend_v_nxt; found_r <= found_nxt;
    end
    e_r <= e_nxt; c_r <= c_nxt; pick_r <= pick_nxt; need_r <= need_nxt;
    faddr_r <= faddr_nxt; lo_r <= lo_nxt; plo_r <= plo_nxt; best_r <= best_nxt;
    pend_a_r <= pend_a_nxt; st_r <= st_nxt; ua_r <= ua_nxt; out_d_r <= out_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

>>> design/fmba_checker.sv
// Port-level checks for the allocator core, attached by bind.
// Depends on fmba_pkg and fit_mode_block_allocator_core.
module fmba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  import fmba_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // failed requests report a zero address
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_OK) |-> out_tdata[17:2] == '0)
    else $error("address on failed request");

  // one request in flight
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // free bytes never exceed the largest pool and the result padding is zero
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[34:18] <= 17'(POOL_BYTES) && out_tdata[39:35] == '0)
    else $error("free bytes above pool or bad result padding");

endmodule

bind fit_mode_block_allocator_core fmba_checker u_fmba_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

>>> dv/fit_mode_block_allocator_core_checker.sv
`timescale 1ns / 1ps
// Checker for the fit-mode block allocator: watches request, result and register
// channels, keeps its own model of the block table and compares every result.
// Depends on fmba_pkg.
module fit_mode_block_allocator_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        in_tuser,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import fmba_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int POOL_MAX    = 65536;
  localparam int HDR         = 32;

  typedef struct packed {
    status_t     status;
    logic [15:0] user_address;
    logic [16:0] free_bytes;
  } alloc_result_t;

  longint   blk_start [TABLE_DEPTH];
  longint   blk_pay   [TABLE_DEPTH];
  int       blk_count;
  longint   free_left;
  fit_t     mode;
  longint   pool_cfg;
  alloc_result_t expected_results[$];

  function automatic longint pool_end();
    return (pool_cfg > POOL_MAX) ? POOL_MAX : pool_cfg;
  endfunction

  function automatic void recount_free();
    longint used;
    used = 0;
    for (int i = 0; i < blk_count; i++) used += HDR + blk_pay[i];
    free_left = (used >= pool_end()) ? 0 : pool_end() - used;
  endfunction

  function automatic alloc_result_t predict_alloc(longint esize, longint ecount);
    alloc_result_t r;
    longint payload, need, lo, hi, gap, best;
    int pick;
    bit found;
    r = '0;
    payload = esize * ecount;
    need = payload + HDR;
    best = 0; pick = 0; found = 0;
    if (blk_count >= TABLE_DEPTH) begin
      r.status = ST_FULL;
    end else if (need > free_left) begin
      r.status = ST_NOFIT;
    end else begin
      for (int g = 0; g <= blk_count; g++) begin
        lo = (g == 0) ? 0 : blk_start[g-1] + HDR + blk_pay[g-1];
        hi = (g == blk_count) ? pool_end() : blk_start[g];
        if (hi > pool_end()) hi = pool_end();
        gap = (hi > lo) ? hi - lo : 0;
        if (gap < need) continue;
        if (mode == FIT_BEST) begin
          if (!found || gap < best) begin best = gap; pick = g; found = 1; end
        end else if (mode == FIT_WORST) begin
          if (!found || gap >= best) begin best = gap; pick = g; found = 1; end
        end else begin
          pick = g; found = 1;
          break;
        end
      end
      if (!found) begin
        r.status = ST_NOFIT;
      end else begin
        lo = (pick == 0) ? 0 : blk_start[pick-1] + HDR + blk_pay[pick-1];
        for (int i = blk_count; i > pick; i--) begin
          blk_start[i] = blk_start[i-1];
          blk_pay[i]   = blk_pay[i-1];
        end
        blk_start[pick] = lo;
        blk_pay[pick]   = payload;
        blk_count++;
        free_left -= need;
        r.status = ST_OK;
        r.user_address = 16'(lo + HDR);
      end
    end
    r.free_bytes = 17'(free_left);
    return r;
  endfunction

  function automatic alloc_result_t predict_release(logic [15:0] addr);
    alloc_result_t r;
    int hit;
    r = '0;
    hit = -1;
    for (int i = 0; i < blk_count; i++)
      if (16'(blk_start[i] + HDR) == addr) begin hit = i; break; end
    if (hit < 0) begin
      r.status = ST_BADFREE;
    end else begin
      free_left += HDR + blk_pay[hit];
      if (free_left > pool_end()) free_left = pool_end();
      for (int k = hit; k + 1 < blk_count; k++) begin
        blk_start[k] = blk_start[k+1];
        blk_pay[k]   = blk_pay[k+1];
      end
      blk_count--;
      r.status = ST_OK;
    end
    r.free_bytes = 17'(free_left);
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst_n) begin
      blk_count = 0;
      mode = FIT_FIRST;
      pool_cfg = POOL_MAX;
      free_left = POOL_MAX;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_FIT_MODE) mode = fit_t'(cfg_data[1:0]);
        else begin
          pool_cfg = longint'(cfg_data);
          recount_free();
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_ALLOC)
          expected_results.insert(expected_results.size(),
            predict_alloc(longint'(in_tdata[15:0]), longint'(in_tdata[31:16])));
        else
          expected_results.insert(expected_results.size(),
            predict_release(in_tdata[47:32]));
      end
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tdata[1:0]);
        got.user_address = out_tdata[17:2];
        got.free_bytes = out_tdata[34:18];
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.user_address !== want.user_address ||
              got.free_bytes !== want.free_bytes) begin
            $display("%0t: expected status %0d addr %h free %0d, got status %0d addr %h free %0d",
                     $time, want.status, want.user_address, want.free_bytes,
                     got.status, got.user_address, got.free_bytes);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> dv/fit_mode_block_allocator_core_test.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request and register stimulus,
// random stalls and the verdict. Depends on fmba_pkg, the block and its checker.
module fit_mode_block_allocator_core_test;
  import fmba_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic        in_tuser = 0;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  logic        cfg_wr_en = 0;
  logic        cfg_index = 0;
  logic [16:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  logic [15:0] live_addrs[$];
  bit          rx_random = 1;

  always #2 clk = ~clk;

  fit_mode_block_allocator_core DUT (.*);

  fit_mode_block_allocator_core_checker checker_i (.*);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stall before each ready while rx_random is set
  initial begin
    int wait_n;
    forever begin
      wait_n = rx_random ? (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 19))) : 0;
      if (wait_n > 0) begin
        out_tready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (out_tdata[1:0] == ST_OK && out_tdata[17:2] != 0)
        live_addrs.insert(live_addrs.size(), out_tdata[17:2]);
    end
  end

  task automatic send_request(logic op, logic [15:0] esize, logic [15:0] ecount,
                              logic [15:0] addr, int gap);
    repeat (gap) @(posedge clk);
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= {addr, ecount, esize};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] value);
    @(posedge clk);
    while (pending != 0 || !in_tready) @(posedge clk);
    repeat (150) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic random_request();
    int kind;
    logic [15:0] a;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      send_request(OP_ALLOC, 16'($urandom_range(1, 64)), 16'($urandom_range(0, 40)),
                   16'($urandom), 0);
    end else if (kind < 80 && live_addrs.size() > 0) begin
      int k;
      k = $urandom_range(0, live_addrs.size() - 1);
      a = live_addrs[k];
      live_addrs.delete(k);
      send_request(!OP_ALLOC, 16'($urandom), 16'($urandom), a, 0);
    end else if (kind < 90) begin
      send_request(OP_ALLOC, 16'($urandom), 16'($urandom), 16'($urandom), 0);
    end else begin
      send_request(!OP_ALLOC, 16'($urandom), 16'($urandom), 16'($urandom), 0);
    end
  endtask

  initial begin
    fit_t modes[4];
    modes = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_RSVD};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: empty-pool fit, zero size, oversize, bad free, wrap
    send_request(OP_ALLOC, 16'hFFFF, 16'hFFFF, 0, 0);
    send_request(OP_ALLOC, 0, 0, 0, 0);
    send_request(OP_ALLOC, 16'd65504, 1, 0, 0);
    send_request(!OP_ALLOC, 0, 0, 16'hFFFF, 0);
    send_request(!OP_ALLOC, 0, 0, 16'd32, 0);
    send_request(OP_ALLOC, 16'd100, 16'd3, 0, 0);
    send_request(OP_ALLOC, 1, 16'd65000, 0, 0);
    send_request(!OP_ALLOC, 0, 0, 16'd0, 0);
    // fill table to overflow
    for (int i = 0; i < 66; i++) send_request(OP_ALLOC, 1, 1, 0, 0);
    write_reg(CFG_POOL_SIZE, 17'd0);
    send_request(OP_ALLOC, 0, 0, 0, 0);
    write_reg(CFG_POOL_SIZE, 17'h1FFFF);
    send_request(!OP_ALLOC, 0, 0, 16'd65, 0);
    for (int ph = 0; ph < 8; ph++) begin
      while (pending != 0) @(posedge clk);
      while (live_addrs.size() > 0) begin
        send_request(!OP_ALLOC, 0, 0, live_addrs.pop_front(), 0);
        while (pending != 0) @(posedge clk);
      end
      write_reg(CFG_FIT_MODE, {15'd0, modes[ph % 4]});
      write_reg(CFG_POOL_SIZE, (ph == 3) ? 17'd4096 : (ph == 5) ? 17'd300 : 17'd65536);
      rx_random = (ph != 2);
      for (int n = 0; n < 170; n++) begin
        if (ph != 2) repeat ($urandom_range(0, 19)) @(posedge clk);
        random_request();
      end
    end
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
